// ===== sv/source_code_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// source_code_tokenizer_macros
// Assertion macros used by the tokenizer top level.
// ----------------------------------------------------------------------------
`ifndef SOURCE_CODE_TOKENIZER_MACROS_SVH
`define SOURCE_CODE_TOKENIZER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sct assertion failed");

// next-cycle implication
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sct assertion failed");

`else

`define SCT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/sct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Types, event codes and byte-class helpers for the source code tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int OUT_OFF_W = 24;

    // event kinds
    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_NONWORD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // lexer mode, one-hot
    typedef enum logic [7:0] {
        M_SPACE      = 8'b0000_0001,
        M_WORD       = 8'b0000_0010,
        M_NUM        = 8'b0000_0100,
        M_DQ         = 8'b0000_1000,
        M_SQ         = 8'b0001_0000,
        M_LINE       = 8'b0010_0000,
        M_BLOCK      = 8'b0100_0000,
        M_BLOCK_OPEN = 8'b1000_0000
    } t_mode;

    // one result item
    typedef struct packed {
        logic [1:0]           kind;
        logic [OUT_OFF_W-1:0] start_off;
        logic [OUT_OFF_W-1:0] end_off;
        logic [7:0]           punct;
        logic                 last;
    } t_event;

    // results of one input byte, handed from lexer to queue
    typedef struct packed {
        logic [1:0] cnt;
        t_event     ev0;
        t_event     ev1;
    } t_push;

    // queue status back to the top level
    typedef struct packed {
        logic [2:0] level;
        logic       room;
    } t_qstat;

    // bytes that may start an identifier (high half included)
    function automatic logic is_start(input logic [7:0] c);
        is_start = c[7] || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
                   || c == 8'h5F || c == 8'h5E;
    endfunction

    // bytes that may continue an identifier
    function automatic logic is_mid(input logic [7:0] c);
        is_mid = is_start(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c < 8'h10) || c == 8'h20;
    endfunction

endpackage

// ===== sv/sct_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_lexer
// Mode tracker: consumes one byte per transfer, updates the lexer state and
// produces up to two events for the output queue.
// ----------------------------------------------------------------------------
module sct_lexer #(
    parameter int OFFSET_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_data,
    input  logic [7:0]     i_look,
    input  logic           i_final,
    output sct_pkg::t_push o_push
);

    sct_pkg::t_mode         r_mode, n_mode;
    logic [7:0]             r_prior, n_prior;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_wstart, n_wstart;

    logic word_hit, tail_hit, do_space;
    logic [1:0] tail_kind;
    logic [7:0] tail_punct;
    logic [31:0] pos_ext, ws_ext;
    logic [sct_pkg::OUT_OFF_W-1:0] pos_o, ws_o;
    sct_pkg::t_event ev_word, ev_tail;

    assign pos_ext = 32'(r_pos);
    assign ws_ext  = 32'(r_wstart);
    assign pos_o   = pos_ext[sct_pkg::OUT_OFF_W-1:0];
    assign ws_o    = ws_ext[sct_pkg::OUT_OFF_W-1:0];

    // next state and event selection
    always_comb begin
        n_mode     = r_mode;
        n_prior    = i_data;
        n_pos      = r_pos + OFFSET_BITS'(1);
        n_wstart   = r_wstart;
        word_hit   = 1'b0;
        tail_hit   = 1'b0;
        tail_kind  = sct_pkg::KIND_NONWORD;
        tail_punct = 8'h00;
        do_space   = 1'b0;

        if (i_final) begin
            word_hit  = (r_mode == sct_pkg::M_WORD);
            tail_hit  = 1'b1;
            tail_kind = sct_pkg::KIND_END;
            n_mode    = sct_pkg::M_SPACE;
            n_prior   = 8'h00;
            n_pos     = '0;
            n_wstart  = '0;
        end else begin
            case (r_mode)
                sct_pkg::M_DQ, sct_pkg::M_SQ: begin
                    if (i_data == ((r_mode == sct_pkg::M_DQ) ? sct_pkg::CH_DQ : sct_pkg::CH_SQ)
                        && r_prior != sct_pkg::CH_BSL) begin
                        n_mode = sct_pkg::M_SPACE;
                    end else if (i_data == sct_pkg::CH_BSL && r_prior == sct_pkg::CH_BSL) begin
                        // escaped backslash escapes nothing
                        n_prior = 8'h00;
                    end
                end
                sct_pkg::M_LINE: begin
                    if (i_data == sct_pkg::CH_NL) n_mode = sct_pkg::M_SPACE;
                end
                sct_pkg::M_BLOCK_OPEN: begin
                    // the opener's star never closes the comment
                    n_mode  = sct_pkg::M_BLOCK;
                    n_prior = 8'h00;
                end
                sct_pkg::M_BLOCK: begin
                    if (i_data == sct_pkg::CH_SLASH && r_prior == sct_pkg::CH_STAR)
                        n_mode = sct_pkg::M_SPACE;
                end
                sct_pkg::M_NUM: begin
                    if (!(i_data == sct_pkg::CH_DOT || sct_pkg::is_mid(i_data))) begin
                        n_mode   = sct_pkg::M_SPACE;
                        do_space = 1'b1;
                    end
                end
                sct_pkg::M_WORD: begin
                    if (!sct_pkg::is_mid(i_data)) begin
                        word_hit = 1'b1;
                        n_mode   = sct_pkg::M_SPACE;
                        do_space = 1'b1;
                    end
                end
                default: begin
                    do_space = 1'b1;
                end
            endcase

            // classify a byte seen outside any token
            if (do_space) begin
                if (i_data == sct_pkg::CH_SLASH && i_look == sct_pkg::CH_STAR) begin
                    n_mode = sct_pkg::M_BLOCK_OPEN;
                end else if (i_data == sct_pkg::CH_SLASH && i_look == sct_pkg::CH_SLASH) begin
                    n_mode = sct_pkg::M_LINE;
                end else if (i_data == sct_pkg::CH_DQ) begin
                    n_mode = sct_pkg::M_DQ;
                end else if (i_data == sct_pkg::CH_SQ) begin
                    n_mode = sct_pkg::M_SQ;
                end else if (sct_pkg::is_start(i_data)) begin
                    n_wstart = r_pos;
                    n_mode   = sct_pkg::M_WORD;
                end else if (sct_pkg::is_mid(i_data)) begin
                    n_mode = sct_pkg::M_NUM;
                end else if (!sct_pkg::is_space(i_data)) begin
                    tail_hit   = 1'b1;
                    tail_punct = i_data;
                end
            end
        end
    end

    // event words
    always_comb begin
        ev_word.kind      = sct_pkg::KIND_WORD;
        ev_word.start_off = ws_o;
        ev_word.end_off   = pos_o;
        ev_word.punct     = 8'h00;
        ev_word.last      = !tail_hit;

        ev_tail.kind      = tail_kind;
        ev_tail.start_off = pos_o;
        ev_tail.end_off   = pos_o;
        ev_tail.punct     = tail_punct;
        ev_tail.last      = 1'b1;

        o_push.cnt = i_take ? ({1'b0, word_hit} + {1'b0, tail_hit}) : 2'd0;
        o_push.ev0 = word_hit ? ev_word : ev_tail;
        o_push.ev1 = ev_tail;
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sct_pkg::M_SPACE;
            r_prior  <= 8'h00;
            r_pos    <= '0;
            r_wstart <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_prior  <= n_prior;
            r_pos    <= n_pos;
            r_wstart <= n_wstart;
        end
    end

endmodule

// ===== sv/sct_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_outq
// Four-entry result queue: takes up to two events per cycle, delivers one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module sct_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sct_pkg::t_push  i_push,
    input  logic            i_ready,
    output logic            o_valid,
    output sct_pkg::t_event o_event,
    output sct_pkg::t_qstat o_stat
);

    localparam int DEPTH = 4;

    sct_pkg::t_event r_mem [DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_level, n_level;
    logic       pop;

    assign o_valid     = (r_level != 3'd0);
    assign o_event     = r_mem[r_rd];
    assign pop         = o_valid && i_ready;
    assign n_level     = r_level + {1'b0, i_push.cnt} - {2'b00, pop};
    assign o_stat.level = r_level;
    // room for a full two-event transfer
    assign o_stat.room  = (r_level <= 3'd2);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.ev0;
        if (i_push.cnt == 2'd2) r_mem[r_wr + 2'd1] <= i_push.ev1;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_level <= 3'd0;
        end else begin
            r_wr    <= r_wr + i_push.cnt;
            r_rd    <= r_rd + {1'b0, pop};
            r_level <= n_level;
        end
    end

endmodule

// ===== sv/source_code_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_code_tokenizer
// C-style source lexer: one byte in, word / nonword / end events out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle with its lookahead byte and a final-byte
// flag; the lexer mode update is combinational, so a byte is
// accepted every cycle while the four-entry result queue has room for two
// events. A byte yields zero, one or two events; the output side drains one
// event per cycle while the receiver is ready, so a byte that ends a word and is
// punctuation (or ends the file inside a word) fills two queue entries that leave
// one at a time. Events are registered in the result queue before they reach the
// output. After the final byte all lexer state returns to its reset values for the next file.
// ----------------------------------------------------------------------------
`include "source_code_tokenizer_macros.svh"

module source_code_tokenizer #(
    parameter int OFFSET_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] lookahead_byte
    input  logic [0:0]  s_axis_tuser,   // [0] final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [1:0] event_kind, [25:2] start_offset,
                                        // [49:26] end_offset, [57:50] punct_byte
    output logic        m_axis_tlast    // last_of_run
);

    sct_pkg::t_push   push;
    sct_pkg::t_event  ev;
    sct_pkg::t_qstat  qstat;
    logic             take;

    assign s_axis_tready = qstat.room;
    assign take          = s_axis_tvalid && s_axis_tready;

    // mode tracker
    sct_lexer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (s_axis_tdata[7:0]),
        .i_look  (s_axis_tdata[15:8]),
        .i_final (s_axis_tuser[0]),
        .o_push  (push)
    );

    // result queue
    sct_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_event (ev),
        .o_stat  (qstat)
    );

    // output packing
    assign m_axis_tdata = {6'b0, ev.punct, ev.end_off, ev.start_off, ev.kind};
    assign m_axis_tlast = ev.last;

    // checks
    `SCT_ASSERT_IMPL(a_level_bound, i_clk, i_rst_n, 1'b1, qstat.level <= 3'd4)
    `SCT_ASSERT_IMPL(a_ready_room, i_clk, i_rst_n, !s_axis_tready, qstat.level > 3'd2)
    `SCT_ASSERT_NEXT(a_final_event, i_clk, i_rst_n, take && s_axis_tuser[0], m_axis_tvalid)
    `SCT_ASSERT_IMPL(a_push_gated, i_clk, i_rst_n, !take, push.cnt == 2'd0)

endmodule

// ===== test/tb_source_code_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_code_tokenizer
// Self-checking bench for the C-style source lexer.
// ----------------------------------------------------------------------------
// Source bytes are fed as small files, each closed by a final padding byte.
// A directed file covers word and number endings, comment open and close
// corners, and quote escapes. Random files follow: mostly well-formed tokens,
// plus truncated files and raw noise. A lexer model in the driver predicts
// the events of every accepted byte; the monitor compares each event transfer
// field by field against the oldest prediction. The sender and the receiver
// idle at random in several phases.
// ----------------------------------------------------------------------------
module tb_source_code_tokenizer;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 450;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic [7:0] la;
        logic       fin;
    } t_src_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'h0000;  // [7:0] data_byte, [15:8] lookahead_byte
    logic [0:0]  s_axis_tuser  = 1'b0;      // [0] final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;              // [1:0] event_kind, [25:2] start_offset,
                                            // [49:26] end_offset, [57:50] punct_byte
    logic        m_axis_tlast;              // last_of_run

    // stimulus and predicted events
    t_src_item        source_bytes[$];
    sct_pkg::t_event  lexer_events[$];
    logic [7:0]       file_text[$];
    int               items_queued = 0;
    int               mismatches   = 0;
    int               cycle_count  = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;

    // lexer state of the model
    sct_pkg::t_mode   lx_mode       = sct_pkg::M_SPACE;
    logic [7:0]       lx_prior      = 8'h00;
    logic [23:0]      lx_pos        = 24'd0;
    logic [23:0]      lx_word_start = 24'd0;

    source_code_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // byte classes: letters, '_', '^' and the high half open a word
    function automatic logic ident_head(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return c[7] || (lc >= 8'h61 && lc <= 8'h7A) || c == 8'h5F || c == 8'h5E;
    endfunction

    function automatic logic ident_body(input logic [7:0] c);
        return ident_head(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c < 8'h10 || c == 8'h20;
    endfunction

    function automatic sct_pkg::t_event token_event(input logic [1:0] kind,
                                                    input logic [23:0] s,
                                                    input logic [23:0] e,
                                                    input logic [7:0] p);
        sct_pkg::t_event ev;
        ev.kind      = kind;
        ev.start_off = s;
        ev.end_off   = e;
        ev.punct     = p;
        ev.last      = 1'b0;
        return ev;
    endfunction

    // advance the lexer by one byte and queue the events it causes
    task automatic lex_byte(input logic [7:0] c, input logic [7:0] la, input logic fin);
        sct_pkg::t_event evs[2];
        int              n;
        sct_pkg::t_mode  m;
        logic [7:0]      np;
        logic            scan;
        n    = 0;
        m    = lx_mode;
        np   = c;
        scan = 1'b0;
        if (fin) begin
            if (m == sct_pkg::M_WORD) begin
                evs[n] = token_event(sct_pkg::KIND_WORD, lx_word_start, lx_pos, 8'h00);
                n++;
            end
            evs[n] = token_event(sct_pkg::KIND_END, lx_pos, lx_pos, 8'h00);
            n++;
            lx_mode       = sct_pkg::M_SPACE;
            lx_prior      = 8'h00;
            lx_pos        = 24'd0;
            lx_word_start = 24'd0;
        end else begin
            case (m)
                sct_pkg::M_DQ, sct_pkg::M_SQ: begin
                    if (c == ((m == sct_pkg::M_DQ) ? sct_pkg::CH_DQ : sct_pkg::CH_SQ)
                        && lx_prior != sct_pkg::CH_BSL) begin
                        m = sct_pkg::M_SPACE;
                    end else if (c == sct_pkg::CH_BSL && lx_prior == sct_pkg::CH_BSL) begin
                        np = 8'h00;  // escaped backslash escapes nothing
                    end
                end
                sct_pkg::M_LINE: begin
                    if (c == sct_pkg::CH_NL) m = sct_pkg::M_SPACE;
                end
                sct_pkg::M_BLOCK_OPEN: begin
                    m  = sct_pkg::M_BLOCK;
                    np = 8'h00;      // opener star never closes
                end
                sct_pkg::M_BLOCK: begin
                    if (c == sct_pkg::CH_SLASH && lx_prior == sct_pkg::CH_STAR)
                        m = sct_pkg::M_SPACE;
                end
                sct_pkg::M_NUM: begin
                    if (!(c == sct_pkg::CH_DOT || ident_body(c))) begin
                        m    = sct_pkg::M_SPACE;
                        scan = 1'b1;
                    end
                end
                sct_pkg::M_WORD: begin
                    if (!ident_body(c)) begin
                        evs[n] = token_event(sct_pkg::KIND_WORD, lx_word_start, lx_pos,
                                             8'h00);
                        n++;
                        m    = sct_pkg::M_SPACE;
                        scan = 1'b1;
                    end
                end
                default: scan = 1'b1;
            endcase
            if (scan) begin
                if (c == sct_pkg::CH_SLASH && la == sct_pkg::CH_STAR) begin
                    m = sct_pkg::M_BLOCK_OPEN;
                end else if (c == sct_pkg::CH_SLASH && la == sct_pkg::CH_SLASH) begin
                    m = sct_pkg::M_LINE;
                end else if (c == sct_pkg::CH_DQ) begin
                    m = sct_pkg::M_DQ;
                end else if (c == sct_pkg::CH_SQ) begin
                    m = sct_pkg::M_SQ;
                end else if (ident_head(c)) begin
                    lx_word_start = lx_pos;
                    m = sct_pkg::M_WORD;
                end else if (ident_body(c)) begin
                    m = sct_pkg::M_NUM;
                end else if (!blank(c)) begin
                    evs[n] = token_event(sct_pkg::KIND_NONWORD, lx_pos, lx_pos, c);
                    n++;
                end
            end
            lx_mode  = m;
            lx_prior = np;
            lx_pos   = lx_pos + 24'd1;
        end
        for (int i = 0; i < n; i++) begin
            evs[i].last = (i == n - 1);
            lexer_events.push_back(evs[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: one byte transfer per handshake, prediction on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_src_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                lex_byte(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tuser[0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (source_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = source_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.la, nxt.data};
                    s_axis_tuser  <= nxt.fin;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare each event transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sct_pkg::t_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (lexer_events.size() == 0) begin
                $error("unexpected event transfer: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = lexer_events.pop_front();
                if (m_axis_tdata[1:0] !== want.kind) begin
                    $error("event_kind: expected %0d, actual %0d", want.kind, m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[25:2] !== want.start_off) begin
                    $error("start_offset: expected %0d, actual %0d",
                           want.start_off, m_axis_tdata[25:2]);
                    mismatches++;
                end
                if (m_axis_tdata[49:26] !== want.end_off) begin
                    $error("end_offset: expected %0d, actual %0d",
                           want.end_off, m_axis_tdata[49:26]);
                    mismatches++;
                end
                if (m_axis_tdata[57:50] !== want.punct) begin
                    $error("punct_byte: expected %h, actual %h", want.punct, m_axis_tdata[57:50]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, actual %0d", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("source_code_tokenizer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // file builders
    // ------------------------------------------------------------------
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
    endtask

    // queue the file as byte items, lookahead mostly the true next byte
    task automatic send_file(input int la_noise_pct);
        t_src_item it;
        for (int i = 0; i < file_text.size(); i++) begin
            it.data = file_text[i];
            it.la   = (i + 1 < file_text.size()) ? file_text[i + 1] : sct_pkg::CH_NL;
            if ($urandom_range(0, 99) < la_noise_pct) it.la = 8'($urandom_range(0, 255));
            it.fin  = 1'b0;
            source_bytes.push_back(it);
        end
        it.data = 8'($urandom_range(0, 255));  // ignored on the final byte
        it.la   = 8'($urandom_range(0, 255));
        it.fin  = 1'b1;
        source_bytes.push_back(it);
        items_queued += file_text.size() + 1;
        file_text.delete();
    endtask

    function automatic logic [7:0] pick_head();
        case ($urandom_range(0, 3))
            0:       return 8'h80 + 8'($urandom_range(0, 127));
            1:       return 8'h61 + 8'($urandom_range(0, 25));
            2:       return 8'h41 + 8'($urandom_range(0, 25));
            default: return $urandom_range(0, 1) ? 8'h5F : 8'h5E;
        endcase
    endfunction

    function automatic logic [7:0] pick_body();
        if ($urandom_range(0, 2) == 0) return 8'h30 + 8'($urandom_range(0, 9));
        return pick_head();
    endfunction

    function automatic logic [7:0] pick_punct();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (ident_body(c) || blank(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 16);
        return (r == 16) ? 8'h20 : 8'(r);
    endfunction

    // string body byte: heavy on backslashes and quotes
    function automatic logic [7:0] pick_quoted();
        case ($urandom_range(0, 5))
            0, 1:    return sct_pkg::CH_BSL;
            2:       return sct_pkg::CH_DQ;
            3:       return sct_pkg::CH_SQ;
            4:       return sct_pkg::CH_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_token();
        logic [7:0] q;
        case ($urandom_range(0, 9))
            0, 1: begin
                file_text.push_back(pick_head());
                repeat ($urandom_range(0, 6)) file_text.push_back(pick_body());
            end
            2: begin
                file_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 4))
                    file_text.push_back($urandom_range(0, 3) == 0 ? sct_pkg::CH_DOT
                                                                  : pick_body());
            end
            3, 4: begin
                q = ($urandom_range(0, 1) == 0) ? sct_pkg::CH_DQ : sct_pkg::CH_SQ;
                file_text.push_back(q);
                repeat ($urandom_range(0, 6)) file_text.push_back(pick_quoted());
                file_text.push_back(q);
            end
            5: begin
                add_text("//");
                repeat ($urandom_range(0, 5)) file_text.push_back(8'($urandom_range(0, 255)));
                file_text.push_back(sct_pkg::CH_NL);
            end
            6: begin
                add_text("/*");
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 2))
                        0:       file_text.push_back(sct_pkg::CH_STAR);
                        1:       file_text.push_back(sct_pkg::CH_SLASH);
                        default: file_text.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                add_text("*/");
            end
            7: file_text.push_back(pick_punct());
            8: repeat ($urandom_range(1, 3)) file_text.push_back(pick_blank());
            default: file_text.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // one random file: tokens, sometimes cut short, sometimes raw noise
    task automatic random_file();
        int cut;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 24)) file_text.push_back(8'($urandom_range(0, 255)));
            send_file(50);
        end else begin
            repeat ($urandom_range(1, 8)) add_token();
            if ($urandom_range(0, 99) < 20) begin
                cut = $urandom_range(0, file_text.size());
                while (file_text.size() > cut) void'(file_text.pop_back());
            end
            send_file(5);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus sequence and end of run
    // ------------------------------------------------------------------
    initial begin
        int target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: word then punct, number with dot into a comment opener,
        // opener star not closing, quote escapes, line comment, high byte
        // word ended by the final byte
        add_text("_a9+ 1./*/*/");
        add_text("'\\''");
        add_text("\"\\\\\"");
        add_text("//\n");
        file_text.push_back(8'hFF);
        send_file(0);

        // hold the sender until every predicted event has been seen
        while (source_bytes.size() != 0 || s_axis_tvalid || lexer_events.size() != 0)
            @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
                random_file();
            while (source_bytes.size() != 0) @(posedge i_clk);
        end

        while (s_axis_tvalid || lexer_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lexer_events.size() != 0) begin
            $error("%0d predicted events never arrived", lexer_events.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("source_code_tokenizer verification clean");
        end else begin
            $display("source_code_tokenizer verification failed");
        end
        $finish;
    end

endmodule

// ===== source_code_tokenizer.f =====
+incdir+sv
sv/sct_pkg.sv
sv/sct_lexer.sv
sv/sct_outq.sv
sv/source_code_tokenizer.sv
test/tb_source_code_tokenizer.sv
